/* hdl/lkvc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants for the LRU key-value cache
// Word formats, controller states and the command and status groups that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   // Storage geometry
   localparam int CAPACITY = 8;
   localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int RANK_W   = SLOT_W;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Field widths fixed by the word formats
   localparam int KEY_W    = 32;
   localparam int VALUE_W  = 32;
   localparam int LIMIT_W  = 4;

   // Request modes
   localparam logic MODE_PUT = 1'b0;
   localparam logic MODE_GET = 1'b1;

   // Value returned when no stored value is read
   localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;

   // Capacity limit after reset
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(CAPACITY);

   typedef struct packed {
      logic                       mode;
      logic [KEY_W-1:0]           key;
      logic signed [VALUE_W-1:0]  write_value;
   } lkvc_req_type;

   typedef struct packed {
      logic                       hit;
      logic signed [VALUE_W-1:0]  read_value;
      logic                       evicted;
      logic [KEY_W-1:0]           evicted_key;
      logic [KEY_W-1:0]           mru_key;
      logic                       mru_valid;
   } lkvc_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } lkvc_state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;   // load the request word
      logic lookup;    // register compare, victim and free-slot results
      logic update;    // write the store and load the result register
   } lkvc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;  // result register can take a new word this cycle
   } lkvc_status_type;

endpackage

/* hdl/lkvc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_ctrl: request sequencer
// Walks each request word through capture, lookup and update, and holds
// the update while the result register is still occupied.
// ----------------------------------------------------------------------------
module lkvc_ctrl import lkvc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  lkvc_status_type status,
   output lkvc_cmd_type    cmd
);

   lkvc_state_type state_ff;
   lkvc_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.out_free) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hdl/lkvc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_datapath: entry store, recency ranks and result register
// Parallel key compare over all entries, victim and free-slot selection,
// rank aging on promote, and the registered result word.
// ----------------------------------------------------------------------------
module lkvc_datapath import lkvc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  lkvc_cmd_type       cmd,
   output lkvc_status_type    status,
   input  lkvc_req_type       req_data,
   input  logic               csr_write_enable,
   input  logic [LIMIT_W-1:0] csr_write_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lkvc_rsp_type       rsp_data
);

   // Request and store
   lkvc_req_type               req_ff;
   logic [KEY_W-1:0]           key_ff   [CAPACITY];
   logic [KEY_W-1:0]           key_in   [CAPACITY];
   logic signed [VALUE_W-1:0]  value_ff [CAPACITY];
   logic signed [VALUE_W-1:0]  value_in [CAPACITY];
   logic [CAPACITY-1:0]        valid_ff;
   logic [CAPACITY-1:0]        valid_in;
   logic [RANK_W-1:0]          rank_ff  [CAPACITY];
   logic [RANK_W-1:0]          rank_in  [CAPACITY];
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   logic [LIMIT_W-1:0]         limit_ff;
   logic [KEY_W-1:0]           mru_key_ff;
   logic [KEY_W-1:0]           mru_key_in;

   // Lookup results
   logic                       hit_ff;
   logic                       hit_in;
   logic [SLOT_W-1:0]          hit_slot_ff;
   logic [SLOT_W-1:0]          hit_slot_in;
   logic [RANK_W-1:0]          hit_rank_ff;
   logic                       full_ff;
   logic                       full_in;
   logic [SLOT_W-1:0]          victim_slot_ff;
   logic [SLOT_W-1:0]          victim_slot_in;
   logic [SLOT_W-1:0]          free_slot_ff;
   logic [SLOT_W-1:0]          free_slot_in;
   logic [CNT_W-1:0]           limit_eff;

   // Update controls
   logic [SLOT_W-1:0]          tgt_slot;
   logic                       change;
   logic                       evict;

   // Result register
   lkvc_rsp_type               rsp_ff;
   lkvc_rsp_type               rsp_in;
   logic                       rsp_valid_ff;

   // Effective limit: zero acts as one, above capacity acts as capacity
   always_comb begin
      if (limit_ff == '0) begin
         limit_eff = CNT_W'(1);
      end else if (32'(limit_ff) > CAPACITY) begin
         limit_eff = CNT_W'(CAPACITY);
      end else begin
         limit_eff = CNT_W'(limit_ff);
      end
   end

   // Parallel compare, victim (oldest rank) and lowest free slot
   always_comb begin
      hit_in         = 1'b0;
      hit_slot_in    = '0;
      victim_slot_in = '0;
      free_slot_in   = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == req_ff.key) begin
            hit_in      = 1'b1;
            hit_slot_in = SLOT_W'(i);
         end
         if (valid_ff[i] && rank_ff[i] == RANK_W'(count_ff - CNT_W'(1))) begin
            victim_slot_in = SLOT_W'(i);
         end
         if (!valid_ff[i]) begin
            free_slot_in = SLOT_W'(i);
         end
      end
      full_in = (count_ff >= limit_eff);
   end

   // Slot to write and whether the recency order moves
   always_comb begin
      if (hit_ff) begin
         tgt_slot = hit_slot_ff;
      end else if (full_ff) begin
         tgt_slot = victim_slot_ff;
      end else begin
         tgt_slot = free_slot_ff;
      end
      change = (req_ff.mode == MODE_PUT) || hit_ff;
      evict  = (req_ff.mode == MODE_PUT) && !hit_ff && full_ff;
   end

   // Store next values; a put miss ages every other valid entry, a hit only the newer ones
   always_comb begin
      valid_in   = valid_ff;
      count_in   = count_ff;
      mru_key_in = mru_key_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         key_in[i]   = key_ff[i];
         value_in[i] = value_ff[i];
         rank_in[i]  = rank_ff[i];
      end
      if (cmd.update && change) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (SLOT_W'(i) == tgt_slot) begin
               rank_in[i]  = '0;
               valid_in[i] = 1'b1;
               if (req_ff.mode == MODE_PUT) begin
                  key_in[i]   = req_ff.key;
                  value_in[i] = req_ff.write_value;
               end
            end else if (valid_ff[i] && (!hit_ff || rank_ff[i] < hit_rank_ff)) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
         if (!hit_ff && !full_ff) begin
            count_in = count_ff + CNT_W'(1);
         end
         mru_key_in = req_ff.key;
      end
   end

   // Result word
   always_comb begin
      rsp_in.hit         = hit_ff;
      rsp_in.read_value  = MISS_VALUE;
      if (req_ff.mode == MODE_GET && hit_ff) begin
         rsp_in.read_value = value_ff[hit_slot_ff];
      end
      rsp_in.evicted     = evict;
      rsp_in.evicted_key = evict ? key_ff[victim_slot_ff] : '0;
      rsp_in.mru_key     = mru_key_in;
      rsp_in.mru_valid   = (count_in != '0);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         mru_key_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff   <= valid_in;
         count_ff   <= count_in;
         mru_key_ff <= mru_key_in;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_ff[i] <= rank_in[i];
         end
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         if (cmd.update) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         key_ff[i]   <= key_in[i];
         value_ff[i] <= value_in[i];
      end
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.lookup) begin
         hit_ff         <= hit_in;
         hit_slot_ff    <= hit_slot_in;
         hit_rank_ff    <= rank_ff[hit_slot_in];
         full_ff        <= full_in;
         victim_slot_ff <= victim_slot_in;
         free_slot_ff   <= free_slot_in;
      end
      if (cmd.update) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

/* hdl/lru_key_value_cache.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache with LRU eviction
// Each request word is a put or a get on a 32-bit key; each gives exactly
// one result word. The number of entries in use is capped by a register.
// ----------------------------------------------------------------------------
// A request is accepted in the idle state, then runs a lookup step (all eight
// stored keys are compared in parallel, and the victim and the lowest free
// slot are picked alongside) and an update step that writes the store, moves
// the recency ranks and loads the result register. The result register lets
// the next request be accepted while a result waits; that request holds in
// its update step until the waiting result is taken. Writing the capacity
// limit takes effect for the next request; a lowered limit never drops
// entries, it only makes later put misses evict.
// ----------------------------------------------------------------------------
module lru_key_value_cache import lkvc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  lkvc_req_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lkvc_rsp_type       rsp_data,
   input  logic               csr_write_enable,
   input  logic [LIMIT_W-1:0] csr_write_data
);

   lkvc_cmd_type    cmd;
   lkvc_status_type status;

   // Sequencer
   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Store and result path
   lkvc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the LRU key-value cache
// Put and get words are fed through the request channel with random gaps.
// Each accepted word runs through a cycle-free model of the cache that
// predicts its result word. Results are compared field by field as they
// leave the block, and the response side stalls at random. The capacity
// limit is rewritten between phases, once the block has drained.
// ----------------------------------------------------------------------------
module testbench;
   import lkvc_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 10;
   localparam int POOL_SIZE    = 12;
   localparam int PHASE_WORDS  = 75;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   lkvc_req_type        req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   lkvc_rsp_type        rsp_data;
   logic                csr_write_enable;
   logic [LIMIT_W-1:0]  csr_write_data;

   // Words waiting to be sent, results waiting to arrive
   lkvc_req_type        pending_words[$];
   lkvc_rsp_type        expected_results[$];

   // Shadow copy of the cache contents
   logic [KEY_W-1:0]    shadow_key[CAPACITY]   = '{default: '0};
   logic [VALUE_W-1:0]  shadow_value[CAPACITY] = '{default: '0};
   bit                  shadow_valid[CAPACITY] = '{default: 1'b0};
   int unsigned         shadow_rank[CAPACITY]  = '{default: 0};
   int unsigned         shadow_count = 0;
   int unsigned         shadow_limit;

   int                  idle_pct;
   int                  error_count = 0;
   int unsigned         cycle_count = 0;
   logic [KEY_W-1:0]    key_pool[POOL_SIZE];

   lru_key_value_cache i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Make slot s the most recent; entries newer than it age by one
   function automatic void promote_slot(int s);
      int unsigned old_rank;
      old_rank = shadow_rank[s];
      for (int i = 0; i < CAPACITY; i++)
         if (shadow_valid[i] && i != s && shadow_rank[i] < old_rank)
            shadow_rank[i]++;
      shadow_rank[s] = 0;
   endfunction

   // Apply one request word to the shadow cache and return its result word
   function automatic lkvc_rsp_type cache_access(lkvc_req_type w);
      lkvc_rsp_type r;
      int           slot;
      int           victim;
      int           free_slot;
      int unsigned  lim;
      r            = '0;
      r.read_value = MISS_VALUE;
      slot         = -1;
      victim       = -1;
      free_slot    = -1;
      lim          = shadow_limit;
      if (lim < 1) lim = 1;
      if (lim > CAPACITY) lim = CAPACITY;

      for (int i = 0; i < CAPACITY; i++)
         if (slot < 0 && shadow_valid[i] && shadow_key[i] == w.key)
            slot = i;

      if (slot >= 0) begin
         r.hit = 1'b1;
         if (w.mode == MODE_GET)
            r.read_value = shadow_value[slot];
         else
            shadow_value[slot] = w.write_value;
         promote_slot(slot);
      end else if (w.mode == MODE_PUT) begin
         if (shadow_count >= lim) begin
            // full: replace the least recent entry
            for (int i = 0; i < CAPACITY; i++)
               if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
                  victim = i;
            if (victim >= 0) begin
               r.evicted            = 1'b1;
               r.evicted_key        = shadow_key[victim];
               shadow_key[victim]   = w.key;
               shadow_value[victim] = w.write_value;
               promote_slot(victim);
            end
         end else begin
            // room left: lowest free slot, everything else ages
            for (int i = 0; i < CAPACITY; i++)
               if (free_slot < 0 && !shadow_valid[i])
                  free_slot = i;
            if (free_slot >= 0) begin
               for (int i = 0; i < CAPACITY; i++)
                  if (shadow_valid[i])
                     shadow_rank[i]++;
               shadow_valid[free_slot] = 1'b1;
               shadow_key[free_slot]   = w.key;
               shadow_value[free_slot] = w.write_value;
               shadow_rank[free_slot]  = 0;
               shadow_count++;
            end
         end
      end

      for (int i = CAPACITY - 1; i >= 0; i--)
         if (shadow_valid[i] && shadow_rank[i] == 0) begin
            r.mru_key   = shadow_key[i];
            r.mru_valid = 1'b1;
         end
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         error_count++;
      end
   endfunction

   function automatic void queue_word(logic mode, logic [KEY_W-1:0] key,
                                      logic [VALUE_W-1:0] value);
      lkvc_req_type w;
      w.mode        = mode;
      w.key         = key;
      w.write_value = value;
      pending_words.push_back(w);
   endfunction

   // Wait until every word is sent and answered, then let the pipeline settle
   task automatic drain();
      do
         @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      shadow_limit      = 32'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Request driver: predicts each accepted word, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && !req_stall)
            expected_results.push_back(cache_access(req_data));
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_data  <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks against the oldest prediction, stalls at random
   always @(posedge clock) begin
      lkvc_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result word with no request outstanding");
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("hit",         32'(want.hit),       32'(rsp_data.hit));
               check_field("read_value",  want.read_value,     rsp_data.read_value);
               check_field("evicted",     32'(want.evicted),   32'(rsp_data.evicted));
               check_field("evicted_key", want.evicted_key,    rsp_data.evicted_key);
               check_field("mru_key",     want.mru_key,        rsp_data.mru_key);
               check_field("mru_valid",   32'(want.mru_valid), 32'(rsp_data.mru_valid));
            end
         end
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Stimulus
   initial begin
      int unsigned limits[10];
      int unsigned eff;
      int unsigned pick;
      logic [KEY_W-1:0] key;

      limits = '{1, 0, 3, 15, 5, 9, 2, 8, 6, 4};
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      idle_pct         = 33;
      shadow_limit     = 32'(LIMIT_RESET);
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset limit
      queue_word(MODE_GET, 32'h0000_0000, 32'h0000_0000);    // get on an empty cache
      queue_word(MODE_PUT, 32'h0000_0000, 32'h7fff_ffff);
      queue_word(MODE_PUT, 32'hffff_ffff, 32'h8000_0000);
      queue_word(MODE_GET, 32'h0000_0000, 32'hffff_ffff);
      queue_word(MODE_GET, 32'hffff_ffff, 32'h1234_5678);
      queue_word(MODE_PUT, 32'h0000_0000, 32'hffff_ffff);    // update in place
      queue_word(MODE_GET, 32'h0000_0000, 32'h0000_0000);    // hit that reads -1
      queue_word(MODE_GET, 32'h1234_5678, 32'h0000_0000);    // miss keeps order
      queue_word(MODE_PUT, 32'haaaa_aaaa, 32'h5555_5555);
      queue_word(MODE_PUT, 32'h5555_5555, 32'haaaa_aaaa);
      queue_word(MODE_PUT, 32'h0000_0001, 32'h0000_0001);
      queue_word(MODE_PUT, 32'h8000_0000, 32'h0000_0000);
      queue_word(MODE_PUT, 32'h7fff_ffff, 32'hdead_beef);
      queue_word(MODE_PUT, 32'h0f0f_0f0f, 32'hf0f0_f0f0);    // cache now full
      queue_word(MODE_PUT, 32'hdead_beef, 32'hcafe_f00d);    // evicts the oldest
      queue_word(MODE_GET, 32'hffff_ffff, 32'h0000_0000);
      queue_word(MODE_GET, 32'h0000_0000, 32'h0000_0000);
      queue_word(MODE_PUT, 32'hcafe_f00d, 32'h0000_0001);
      queue_word(MODE_GET, 32'h0000_0001, 32'h0000_0000);
      queue_word(MODE_PUT, 32'h1357_9bdf, 32'h2468_ace0);
      drain();

      // Random phases, each at a new limit; one runs with no idling at all
      foreach (limits[p]) begin
         write_limit(LIMIT_W'(limits[p]));
         idle_pct = (p == 3) ? 0 : 33;
         eff = limits[p];
         if (eff < 1) eff = 1;
         if (eff > CAPACITY) eff = CAPACITY;
         for (int i = 0; i < 3; i++)
            key_pool[$urandom_range(POOL_SIZE - 1)] = $urandom;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            pick = $urandom_range(99);
            if (pick < 10)
               key = $urandom;
            else
               key = key_pool[$urandom_range(eff + 1)];
            queue_word(1'($urandom_range(1)), key, $urandom);
         end
         drain();
      end

      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

/* sim.f */
hdl/lkvc_pkg.sv
hdl/lkvc_ctrl.sv
hdl/lkvc_datapath.sv
hdl/lru_key_value_cache.sv
verif/testbench.sv
